@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the filter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every edge outside reset
`define SFZP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every edge outside reset
`define SFZP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/sfzp_pkg.sv @@
// Constants and shared types of the symmetric FIR block
package sfzp_pkg;

  localparam int MAX_HALF    = 63;
  localparam int SAMPLE_BITS = 32;
  localparam int HALF_W      = 6;   // half_len and coef_index field width
  localparam int TAP_W       = 18;  // Q1.17 weight
  localparam int FRAC_BITS   = 17;
  localparam int ROUND_HALF  = 1 << (FRAC_BITS - 1);

  localparam int TAP_DEPTH = MAX_HALF + 1;
  localparam int TAP_AW    = $clog2(TAP_DEPTH);
  localparam int WIN_SPAN  = 2 * MAX_HALF + 1;
  localparam int WIN_AW    = $clog2(WIN_SPAN);
  localparam int WIN_DEPTH = 1 << WIN_AW;
  localparam int SEEN_W    = $clog2(WIN_SPAN + 1);

  localparam int PAIR_W = SAMPLE_BITS + 1;
  localparam int PROD_W = PAIR_W + TAP_W + 1;
  localparam int ACC_W  = PROD_W + TAP_AW;
  localparam int Q_W    = ACC_W - FRAC_BITS;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // One multiply-accumulate term travelling from the sequencer to the datapath
  typedef struct packed {
    logic vld;
    logic first;     // first term of a sum
    logic fin;       // final term of a sum
    logic last_out;  // sum is the record's final result
    logic use_a;     // lower-side sample lies inside the record
    logic use_b;     // upper-side sample lies inside the record
    logic use_t;     // weight has been loaded since reset
  } sfzp_term_t;

endpackage

@@ hw/rtl/sfzp_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module sfzp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/sfzp_seq.sv @@
// Sequencer: input beats, window pointer, record count and tap-pair issue
`include "assert_macros.svh"

module sfzp_seq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [sfzp_pkg::HALF_W-1:0]       coef_index,
  input  logic                              last_sample,
  input  logic                              cfg_write_en,
  input  logic [sfzp_pkg::HALF_W-1:0]       cfg_write_data,
  input  logic                              mac_busy,
  output logic                              win_we,
  output logic [sfzp_pkg::WIN_AW-1:0]       win_waddr,
  output logic [sfzp_pkg::WIN_AW-1:0]       win_raddr_a,
  output logic [sfzp_pkg::WIN_AW-1:0]       win_raddr_b,
  output logic                              tap_we,
  output logic [sfzp_pkg::TAP_AW-1:0]       tap_waddr,
  output logic [sfzp_pkg::TAP_AW-1:0]       tap_raddr,
  output sfzp_pkg::sfzp_term_t              term
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_ISSUE = 4'b0100,
    S_ADV   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [sfzp_pkg::HALF_W-1:0]    half_len;
  logic [sfzp_pkg::TAP_AW-1:0]    l_cur, l_eff, j, z;
  logic [sfzp_pkg::WIN_AW-1:0]    wp;
  logic [sfzp_pkg::SEEN_W-1:0]    seen;
  logic                           last_item;
  logic [sfzp_pkg::TAP_DEPTH-1:0] tap_ok;

  logic                           in_acc, load_ok, emit;
  logic [sfzp_pkg::WIN_AW-1:0]    k_a, k_b;
  logic [sfzp_pkg::WIN_AW:0]      m_a, m_b;
  logic                           ok_a, ok_b;
  sfzp_pkg::sfzp_term_t           term_next;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_ok  = int'(coef_index) <= sfzp_pkg::MAX_HALF;
  assign l_eff    = (int'(half_len) > sfzp_pkg::MAX_HALF) ?
                    sfzp_pkg::TAP_AW'(sfzp_pkg::MAX_HALF) : sfzp_pkg::TAP_AW'(half_len);

  assign win_we    = in_acc && (cmd == sfzp_pkg::CMD_SAMPLE);
  assign win_waddr = wp + 1'b1;
  assign tap_we    = in_acc && (cmd == sfzp_pkg::CMD_LOAD) && load_ok;
  assign tap_waddr = coef_index[sfzp_pkg::TAP_AW-1:0];
  assign tap_raddr = j;

  // result z of a flush exists once the record plus z padding zeros covers the kernel
  assign emit = ({1'b0, seen} + (sfzp_pkg::SEEN_W + 1)'(z)) >
                (sfzp_pkg::SEEN_W + 1)'(l_cur);

  // window index k after z zero shifts maps to record age k - z
  always_comb begin
    k_a = sfzp_pkg::WIN_AW'(l_cur) - sfzp_pkg::WIN_AW'(j);
    k_b = sfzp_pkg::WIN_AW'(l_cur) + sfzp_pkg::WIN_AW'(j);
    m_a = {1'b0, k_a} - (sfzp_pkg::WIN_AW + 1)'(z);
    m_b = {1'b0, k_b} - (sfzp_pkg::WIN_AW + 1)'(z);
    ok_a = !m_a[sfzp_pkg::WIN_AW] &&
           ({1'b0, m_a[sfzp_pkg::WIN_AW-1:0]} < (sfzp_pkg::WIN_AW + 1)'(seen));
    ok_b = !m_b[sfzp_pkg::WIN_AW] &&
           ({1'b0, m_b[sfzp_pkg::WIN_AW-1:0]} < (sfzp_pkg::WIN_AW + 1)'(seen));
    win_raddr_a = wp - m_a[sfzp_pkg::WIN_AW-1:0];
    win_raddr_b = wp - m_b[sfzp_pkg::WIN_AW-1:0];

    term_next          = '0;
    term_next.vld      = (state == S_ISSUE);
    term_next.first    = (j == '0);
    term_next.fin      = (j == l_cur);
    term_next.last_out = last_item && (z == l_cur);
    term_next.use_a    = ok_a;
    term_next.use_b    = ok_b && (j != '0);
    term_next.use_t    = tap_ok[j];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && (cmd == sfzp_pkg::CMD_SAMPLE)) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!emit) state_next = S_ADV;
        else if (!mac_busy) state_next = S_ISSUE;
      end
      S_ISSUE: begin
        if (j == l_cur) state_next = S_ADV;
      end
      S_ADV: begin
        if (last_item && (z != l_cur)) state_next = S_CHECK;
        else state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      half_len  <= '0;
      l_cur     <= '0;
      j         <= '0;
      z         <= '0;
      wp        <= '0;
      seen      <= '0;
      last_item <= 1'b0;
      tap_ok    <= '0;
      term      <= '0;
    end else begin
      state <= state_next;
      term  <= term_next;
      if (cfg_write_en) half_len <= cfg_write_data;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (cmd == sfzp_pkg::CMD_LOAD) begin
              if (load_ok) tap_ok[tap_waddr] <= 1'b1;
            end else begin
              wp        <= wp + 1'b1;
              last_item <= last_sample;
              z         <= '0;
              l_cur     <= l_eff;
              if (seen != sfzp_pkg::SEEN_W'(sfzp_pkg::WIN_SPAN)) seen <= seen + 1'b1;
            end
          end
        end
        S_CHECK: j <= '0;
        S_ISSUE: j <= j + 1'b1;
        S_ADV: begin
          if (last_item && (z != l_cur)) z <= z + 1'b1;
          else if (last_item) seen <= '0;  // record done, window reads as zeros
        end
        default: ;
      endcase
    end
  end

  `SFZP_ASSERT_IMP(a_pair_in_range, state == S_ISSUE, j <= l_cur, "tap pair beyond half length")
  `SFZP_ASSERT_NEXT(a_record_cleared, state == S_ADV && last_item && z == l_cur, seen == '0 && state == S_IDLE, "record not cleared after flush")

endmodule

@@ hw/rtl/sfzp_mac.sv @@
// Shared pre-add, multiply and accumulate unit with rounding and output register
`include "assert_macros.svh"

module sfzp_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  sfzp_pkg::sfzp_term_t                term,
  input  logic [sfzp_pkg::SAMPLE_BITS-1:0]    win_a,
  input  logic [sfzp_pkg::SAMPLE_BITS-1:0]    win_b,
  input  logic [sfzp_pkg::TAP_W-1:0]          tap,
  output logic                                busy,
  output logic [sfzp_pkg::SAMPLE_BITS-1:0]    filtered,
  output logic                                last_out,
  output logic                                out_valid,
  input  logic                                out_ready
);

  sfzp_pkg::sfzp_term_t                     p1, p2;
  logic signed [sfzp_pkg::PAIR_W-1:0]       ext_a, ext_b, psum;
  logic [sfzp_pkg::TAP_W-1:0]               tap_q;
  logic signed [sfzp_pkg::PROD_W-1:0]       prod;
  logic signed [sfzp_pkg::ACC_W-1:0]        acc, rsum;
  logic                                     acc_done, acc_last, take, ovf;
  logic [sfzp_pkg::Q_W-1:0]                 q;
  logic [sfzp_pkg::SAMPLE_BITS-1:0]         sat;

  assign ext_a = term.use_a ? {win_a[sfzp_pkg::SAMPLE_BITS-1], win_a} : '0;
  assign ext_b = term.use_b ? {win_b[sfzp_pkg::SAMPLE_BITS-1], win_b} : '0;

  // round half up at the Q1.17 point, then clamp to the sample range
  assign rsum = acc + sfzp_pkg::ACC_W'(sfzp_pkg::ROUND_HALF);
  assign q    = rsum[sfzp_pkg::ACC_W-1:sfzp_pkg::FRAC_BITS];
  assign ovf  = q[sfzp_pkg::Q_W-1:sfzp_pkg::SAMPLE_BITS-1] !=
                {(sfzp_pkg::Q_W - sfzp_pkg::SAMPLE_BITS + 1){q[sfzp_pkg::Q_W-1]}};
  assign sat  = !ovf ? q[sfzp_pkg::SAMPLE_BITS-1:0] :
                q[sfzp_pkg::Q_W-1] ? {1'b1, {(sfzp_pkg::SAMPLE_BITS-1){1'b0}}} :
                                     {1'b0, {(sfzp_pkg::SAMPLE_BITS-1){1'b1}}};

  assign take = acc_done && (!out_valid || out_ready);
  assign busy = term.vld || p1.vld || p2.vld || acc_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1        <= '0;
      p2        <= '0;
      acc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1 <= term;
      p2 <= p1;
      if (p2.vld && p2.fin) acc_done <= 1'b1;
      else if (take) acc_done <= 1'b0;
      if (take) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    psum  <= ext_a + ext_b;
    tap_q <= term.use_t ? tap : '0;
    prod  <= psum * $signed({1'b0, tap_q});
    if (p2.vld) begin
      acc      <= p2.first ? sfzp_pkg::ACC_W'(prod) : acc + sfzp_pkg::ACC_W'(prod);
      acc_last <= p2.last_out;
    end
    if (take) begin
      filtered <= sat;
      last_out <= acc_last;
    end
  end

  `SFZP_ASSERT_IMP(a_no_overlap, p2.vld && p2.first, !acc_done, "new sum started over an unrounded one")
  `SFZP_ASSERT_NEXT(a_result_moves, acc_done && !(out_valid && !out_ready), out_valid && !acc_done, "finished sum not moved to output")

endmodule

@@ hw/rtl/symmetric_fir_zero_padded.sv @@
// Load beats leave the input open; out_valid rises once the sum for a sample beat with a result is rounded.
// Each result costs one multiply-accumulate per tap pair (L = half_len);
// the input reopens once such a beat's tap pairs are issued; a last-marked sample flushes up to L + 1
// results one after another. The shared multiplier sets the per-pair cost.
// Reset clears control, the record count and tap-valid flags: unloaded taps read as zero,
// and the window reads as zero outside the record, so no clearing pass is needed.
module symmetric_fir_zero_padded (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [sfzp_pkg::HALF_W-1:0]         coef_index,
  input  logic [sfzp_pkg::TAP_W-1:0]          coef_value,
  input  logic [sfzp_pkg::SAMPLE_BITS-1:0]    sample,
  input  logic                                last_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sfzp_pkg::SAMPLE_BITS-1:0]    filtered,
  output logic                                last_out,
  input  logic                                cfg_write_en,
  input  logic [sfzp_pkg::HALF_W-1:0]         cfg_write_data
);

  logic                             win_we, tap_we, mac_busy;
  logic [sfzp_pkg::WIN_AW-1:0]      win_waddr, win_raddr_a, win_raddr_b;
  logic [sfzp_pkg::TAP_AW-1:0]      tap_waddr, tap_raddr;
  logic [sfzp_pkg::SAMPLE_BITS-1:0] win_a, win_b;
  logic [sfzp_pkg::TAP_W-1:0]       tap_rd;
  sfzp_pkg::sfzp_term_t             term;

  sfzp_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .coef_index     (coef_index),
    .last_sample    (last_sample),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .mac_busy       (mac_busy),
    .win_we         (win_we),
    .win_waddr      (win_waddr),
    .win_raddr_a    (win_raddr_a),
    .win_raddr_b    (win_raddr_b),
    .tap_we         (tap_we),
    .tap_waddr      (tap_waddr),
    .tap_raddr      (tap_raddr),
    .term           (term)
  );

  // two copies of the window so both sides of a tap pair are read in the same cycle
  sfzp_ram #(.WIDTH(sfzp_pkg::SAMPLE_BITS), .DEPTH(sfzp_pkg::WIN_DEPTH)) u_win_a (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (sample),
    .raddr (win_raddr_a),
    .rdata (win_a)
  );

  sfzp_ram #(.WIDTH(sfzp_pkg::SAMPLE_BITS), .DEPTH(sfzp_pkg::WIN_DEPTH)) u_win_b (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (sample),
    .raddr (win_raddr_b),
    .rdata (win_b)
  );

  sfzp_ram #(.WIDTH(sfzp_pkg::TAP_W), .DEPTH(sfzp_pkg::TAP_DEPTH)) u_taps (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (coef_value),
    .raddr (tap_raddr),
    .rdata (tap_rd)
  );

  sfzp_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .term      (term),
    .win_a     (win_a),
    .win_b     (win_b),
    .tap       (tap_rd),
    .busy      (mac_busy),
    .filtered  (filtered),
    .last_out  (last_out),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

@@ verif/tb_symmetric_fir_zero_padded.sv @@
// Self-checking testbench for the zero-padded symmetric FIR: scoreboard, beat drivers and stimulus
`timescale 1ns / 1ps

module tb_symmetric_fir_zero_padded;

  localparam longint SAT_HI = (longint'(1) << (sfzp_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  // longest quiet spell of a correct block: a full-span sum plus margin
  localparam int SETTLE     = 2 * (sfzp_pkg::MAX_HALF + 7) + 20;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_BEATS = 260;

  typedef struct packed {
    logic [sfzp_pkg::SAMPLE_BITS-1:0] filtered;
    logic                             last_out;
  } fir_result_t;

  class fir_scoreboard;
    longint      win [sfzp_pkg::WIN_SPAN];   // newest sample at 0
    longint      coef [sfzp_pkg::TAP_DEPTH];
    int          seen;
    int          span;             // half_len
    int          errors;
    fir_result_t due_outputs [$];

    function new();
      clear_record();
      foreach (coef[k]) coef[k] = 0;
      span   = 0;
      errors = 0;
    endfunction

    function void clear_record();
      foreach (win[k]) win[k] = 0;
      seen = 0;
    endfunction

    function void shift_in(longint s);
      for (int k = sfzp_pkg::WIN_SPAN - 1; k > 0; k--) win[k] = win[k - 1];
      win[0] = s;
    endfunction

    // centre sits span places back in the window
    function fir_result_t weighted_sum(logic mark);
      longint      acc;
      longint      q;
      fir_result_t r;
      acc = coef[0] * win[span];
      for (int j = 1; j <= span; j++) acc += coef[j] * (win[span - j] + win[span + j]);
      // floor after adding half: ties go up
      q = (acc + sfzp_pkg::ROUND_HALF) >>> sfzp_pkg::FRAC_BITS;
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      r.filtered = q[sfzp_pkg::SAMPLE_BITS-1:0];
      r.last_out = mark;
      return r;
    endfunction

    function void accept_beat(logic c, logic [sfzp_pkg::HALF_W-1:0] idx,
                              logic [sfzp_pkg::TAP_W-1:0] val,
                              logic [sfzp_pkg::SAMPLE_BITS-1:0] smp, logic lst);
      int n;
      if (c == sfzp_pkg::CMD_LOAD) begin
        coef[idx] = val;
        return;
      end
      shift_in(longint'($signed(smp)));
      if (seen < sfzp_pkg::WIN_SPAN) seen++;
      n = seen;
      if (n > span) due_outputs.push_back(weighted_sum(lst && span == 0));
      if (lst) begin
        // flush as if zeros followed the record
        for (int z = 1; z <= span; z++) begin
          shift_in(0);
          if (n + z > span) due_outputs.push_back(weighted_sum(z == span));
        end
        clear_record();
      end
    endfunction

    function void check_result(logic [sfzp_pkg::SAMPLE_BITS-1:0] got_f, logic got_l);
      fir_result_t want;
      if (due_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, filtered %0d last_out %0b", $time, $signed(got_f), got_l);
        return;
      end
      want = due_outputs.pop_front();
      if (got_f !== want.filtered || got_l !== want.last_out) begin
        errors++;
        $display("%0t: filtered exp %0d got %0d, last_out exp %0b got %0b", $time,
                 $signed(want.filtered), $signed(got_f), want.last_out, got_l);
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             cmd = sfzp_pkg::CMD_LOAD;
  logic [sfzp_pkg::HALF_W-1:0]      coef_index = '0;
  logic [sfzp_pkg::TAP_W-1:0]       coef_value = '0;
  logic [sfzp_pkg::SAMPLE_BITS-1:0] sample = '0;
  logic                             last_sample = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [sfzp_pkg::SAMPLE_BITS-1:0] filtered;
  logic                             last_out;
  logic                             cfg_write_en = 1'b0;
  logic [sfzp_pkg::HALF_W-1:0]      cfg_write_data = '0;

  fir_scoreboard sb = new();

  int beats_sent  = 0;
  int burst_left  = 1;
  int gap_max     = 0;
  int stall_pct   = 0;
  int stall_max   = 0;
  int stall_left  = 0;
  int idle_cycles = 0;

  symmetric_fir_zero_padded dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .coef_index    (coef_index),
    .coef_value    (coef_value),
    .sample        (sample),
    .last_sample   (last_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .filtered      (filtered),
    .last_out      (last_out),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always #5 clk = ~clk;

  // receiver: random stalls of random length, rate set per phase
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, stall_max);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(filtered, last_out);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("symmetric_fir_zero_padded: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a rising edge; valid stays up into the next beat unless a gap follows
  task automatic send_beat(logic c, logic [sfzp_pkg::HALF_W-1:0] idx,
                           logic [sfzp_pkg::TAP_W-1:0] val,
                           logic [sfzp_pkg::SAMPLE_BITS-1:0] smp, logic lst);
    int gap;
    in_valid    <= 1'b1;
    cmd         <= c;
    coef_index  <= idx;
    coef_value  <= val;
    sample      <= smp;
    last_sample <= lst;
    do @(posedge clk); while (!in_ready);
    sb.accept_beat(c, idx, val, smp, lst);
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_half_len(logic [sfzp_pkg::HALF_W-1:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.span = v;
  endtask

  initial begin
    int                               hl;
    int                               tap_cap;
    int                               n_rec;
    int                               len;
    bit                               keep_open;
    logic [sfzp_pkg::SAMPLE_BITS-1:0] smp;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_half_len(6'd0);
    // unloaded taps read as zero
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd63, 18'h3FFFF, 32'h7FFFFFFF, 1'b0);
    // unity centre tap: identity, extremes pass through
    send_beat(sfzp_pkg::CMD_LOAD, 6'd0, 18'd131072, 32'hFFFFFFFF, 1'b1);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'h7FFFFFFF, 1'b0);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'h80000000, 1'b0);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'hFFFFFFFF, 1'b1);
    // smallest weight: half an LSB rounds towards plus infinity
    send_beat(sfzp_pkg::CMD_LOAD, 6'd0, 18'd1, 32'h0, 1'b0);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'd65536, 1'b0);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'hFFFF0000, 1'b0);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'd65535, 1'b0);
    // weight above unity saturates both ways
    send_beat(sfzp_pkg::CMD_LOAD, 6'd0, 18'h3FFFF, 32'h0, 1'b0);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'h7FFFFFFF, 1'b0);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'h80000000, 1'b1);
    wait_idle();

    write_half_len(6'd1);
    send_beat(sfzp_pkg::CMD_LOAD, 6'd0, 18'd131072, 32'h0, 1'b0);
    send_beat(sfzp_pkg::CMD_LOAD, 6'd1, 18'd65536, 32'h0, 1'b0);
    // record shorter than the span: everything comes out in the flush
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'd1000, 1'b1);
    // tap load inside a record, then the span changes mid-record
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'd100, 1'b0);
    send_beat(sfzp_pkg::CMD_LOAD, 6'd1, 18'd32768, 32'h0, 1'b0);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'd200, 1'b0);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'd300, 1'b0);
    wait_idle();
    write_half_len(6'd2);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'd400, 1'b1);
    wait_idle();

    // widest span, short record
    write_half_len(6'd63);
    send_beat(sfzp_pkg::CMD_LOAD, 6'd63, 18'd131072, 32'h0, 1'b0);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'h7FFFFFFF, 1'b0);
    send_beat(sfzp_pkg::CMD_SAMPLE, 6'd0, 18'd0, 32'h80000000, 1'b1);

    beats_sent = 0;
    while (beats_sent < RAND_BEATS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       hl = 0;
        1:       hl = 63;
        2, 3, 4, 5: hl = $urandom_range(0, 4);
        6, 7, 8: hl = $urandom_range(5, 15);
        default: hl = $urandom_range(16, 62);
      endcase
      write_half_len(6'(hl));
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
      stall_max = $urandom_range(0, 15);
      tap_cap   = ($urandom_range(0, 3) == 0) ? 18'h3FFFF : 131072 / (2 * hl + 1);

      repeat ($urandom_range(1, 6)) begin
        send_beat(sfzp_pkg::CMD_LOAD,
                  6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) :
                     $urandom_range(0, hl)),
                  18'($urandom_range(0, tap_cap)), $urandom(),
                  1'($urandom_range(0, 1)));
      end

      n_rec     = $urandom_range(1, 3);
      keep_open = ($urandom_range(0, 4) == 0);
      for (int r = 0; r < n_rec; r++) begin
        // now and then a record long enough to fill, or nearly fill, the whole window
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(120, 140) : $urandom_range(1, hl + 8);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 15) == 0) begin
            send_beat(sfzp_pkg::CMD_LOAD, 6'($urandom_range(0, hl)),
                      18'($urandom_range(0, tap_cap)), $urandom(),
                      1'($urandom_range(0, 1)));
          end
          case ($urandom_range(0, 7))
            0, 1:    smp = $urandom();
            2:       smp = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            3:       smp = $signed($urandom()) >>> 10;
            default: smp = $urandom_range(0, 4000) - 2000;
          endcase
          send_beat(sfzp_pkg::CMD_SAMPLE, 6'($urandom_range(0, 63)),
                    18'($urandom_range(0, 18'h3FFFF)), smp,
                    (k == len - 1) && !(keep_open && r == n_rec - 1));
        end
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.due_outputs.size() == 0) begin
      $display("symmetric_fir_zero_padded: match");
    end else begin
      $display("symmetric_fir_zero_padded: mismatch");
    end
    $finish;
  end

endmodule
